/* hw/rtl/tblc_pkg.sv */
package tblc_pkg;

   localparam int TIME_W    = 23;
   localparam int DT_W      = 21;
   localparam int LONG_W    = 20;
   localparam int REPEAT_W  = 18;
   localparam int LEVEL_W   = 5;
   localparam int INTENS_W  = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [TIME_W-1:0] TIME_SAT = {TIME_W{1'b1}};

   localparam logic [TIME_W-1:0]   IDLE_LIMIT_RST = TIME_W'(1500000);
   localparam logic [TIME_W-1:0]   OFF_HOLD_RST   = TIME_W'(100000);
   localparam logic [LONG_W-1:0]   LONG_PRESS_RST = LONG_W'(400000);
   localparam logic [REPEAT_W-1:0] REPEAT_RST     = REPEAT_W'(200000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IDLE_LIMIT = 2'd0,
      CSR_OFF_HOLD   = 2'd1,
      CSR_LONG_PRESS = 2'd2,
      CSR_REPEAT     = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [TIME_W-1:0]   idle_limit;
      logic [TIME_W-1:0]   off_hold;
      logic [LONG_W-1:0]   long_press;
      logic [REPEAT_W-1:0] repeat_ivl;
      logic [TIME_W-1:0]   cap;
   } csr_type;

   typedef struct packed {
      logic               up;
      logic               down;
      logic [DT_W-1:0]    elapsed;
   } step_in_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               run;
      logic               pulse;
   } step_out_type;

endpackage

/* hw/rtl/tblc_csr.sv */
module tblc_csr #(
   parameter int LEVEL_MAX = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tblc_pkg::CSR_IDX_W-1:0]   csr_addr,
   input  logic [tblc_pkg::TIME_W-1:0]      csr_wdata,
   output tblc_pkg::csr_type                csr_o
);
   import tblc_pkg::*;

   localparam logic [LEVEL_W-1:0] LVL_MAX_V = LEVEL_W'(LEVEL_MAX);

   logic [TIME_W-1:0]   idle_limit_ff, off_hold_ff, cap_ff, cap_in;
   logic [LONG_W-1:0]   long_press_ff;
   logic [REPEAT_W-1:0] repeat_ff;
   logic [TIME_W-1:0]   rep_prod;
   logic [TIME_W:0]     cap_sum;

   // cap follows the registers in the next cycle; writes are to come only while idle, which the block does not enforce
   always_comb begin
      rep_prod = TIME_W'(repeat_ff) * TIME_W'(LVL_MAX_V);
      cap_sum  = {1'b0, rep_prod} + (TIME_W+1)'(long_press_ff);
      cap_in   = (cap_sum > (TIME_W+1)'(TIME_SAT)) ? TIME_SAT : cap_sum[TIME_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= IDLE_LIMIT_RST;
         off_hold_ff   <= OFF_HOLD_RST;
         long_press_ff <= LONG_PRESS_RST;
         repeat_ff     <= REPEAT_RST;
         cap_ff        <= '0;
      end else begin
         cap_ff <= cap_in;
         if (csr_we) begin
            case (csr_idx_type'(csr_addr))
               CSR_IDLE_LIMIT: idle_limit_ff <= csr_wdata;
               CSR_OFF_HOLD:   off_hold_ff   <= csr_wdata;
               CSR_LONG_PRESS: long_press_ff <= csr_wdata[LONG_W-1:0];
               CSR_REPEAT:     repeat_ff     <= csr_wdata[REPEAT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign csr_o.idle_limit = idle_limit_ff;
   assign csr_o.off_hold   = off_hold_ff;
   assign csr_o.long_press = long_press_ff;
   assign csr_o.repeat_ivl = repeat_ff;
   assign csr_o.cap        = cap_ff;

endmodule

/* hw/rtl/tblc_step.sv */
module tblc_step #(
   parameter int LEVEL_MAX = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  tblc_pkg::csr_type      csr_i,
   input  tblc_pkg::step_in_type  step_i,
   output tblc_pkg::step_out_type step_o
);
   import tblc_pkg::*;

   localparam logic [LEVEL_W-1:0] LVL_MAX_V = LEVEL_W'(LEVEL_MAX);
   localparam logic [LEVEL_W-1:0] LVL_MIN_V = LEVEL_W'(1);

   logic [TIME_W-1:0]  idle_ff, idle_in, up_ff, up_in, dn_ff, dn_in, mark_ff, mark_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               run_ff, run_in;
   logic [TIME_W:0]    idle_sum, up_sum, dn_sum;
   logic [TIME_W-1:0]  up_sat, dn_sat, held, prior_held;
   logic               active, pulse, act_up, step_lvl;

   always_comb begin
      idle_sum = (TIME_W+1)'(idle_ff) + (TIME_W+1)'(step_i.elapsed);
      up_sum   = (TIME_W+1)'(up_ff) + (TIME_W+1)'(step_i.elapsed);
      dn_sum   = (TIME_W+1)'(dn_ff) + (TIME_W+1)'(step_i.elapsed);
      up_sat   = (up_sum < (TIME_W+1)'(csr_i.cap)) ? up_sum[TIME_W-1:0] : csr_i.cap;
      dn_sat   = (dn_sum < (TIME_W+1)'(csr_i.cap)) ? dn_sum[TIME_W-1:0] : csr_i.cap;
      active   = (idle_sum >= (TIME_W+1)'(csr_i.idle_limit));

      idle_in    = active ? csr_i.idle_limit : idle_sum[TIME_W-1:0];
      up_in      = up_ff;
      dn_in      = dn_ff;
      mark_in    = mark_ff;
      level_in   = level_ff;
      run_in     = run_ff;
      pulse      = 1'b0;
      act_up     = 1'b0;
      held       = '0;
      prior_held = '0;
      step_lvl   = 1'b0;

      if (active) begin
         if (step_i.up) begin
            up_in = up_sat;
         end else if (up_ff != '0) begin
            up_in   = '0;
            mark_in = '0;
         end
         if (step_i.down) begin
            dn_in = dn_sat;
         end else if (dn_ff != '0) begin
            dn_in   = '0;
            mark_in = '0;
         end

         if (up_in != '0 && dn_in != '0) begin
            if (up_in >= csr_i.off_hold && dn_in >= csr_i.off_hold) begin
               pulse   = 1'b1;
               run_in  = 1'b0;
               idle_in = '0;
               up_in   = '0;
               dn_in   = '0;
               mark_in = '0;
            end
         end else if (up_in != '0 || dn_in != '0) begin
            run_in     = 1'b1;
            act_up     = (up_in != '0);
            held       = act_up ? up_in : dn_in;
            prior_held = act_up ? up_ff : dn_ff;
            if (prior_held == '0) begin
               step_lvl = 1'b1;
            end else if (held >= TIME_W'(csr_i.long_press) && held >= mark_in &&
                         (held - mark_in) >= TIME_W'(csr_i.repeat_ivl)) begin
               step_lvl = 1'b1;
               mark_in  = held;
            end
         end
      end

      if (step_lvl) begin
         if (act_up) begin
            if (level_ff < LVL_MAX_V) level_in = level_ff + LEVEL_W'(1);
         end else begin
            if (level_ff > LVL_MIN_V) level_in = level_ff - LEVEL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff  <= '0;
         up_ff    <= '0;
         dn_ff    <= '0;
         mark_ff  <= '0;
         level_ff <= LVL_MIN_V;
         run_ff   <= 1'b1;
      end else if (fire) begin
         idle_ff  <= idle_in;
         up_ff    <= up_in;
         dn_ff    <= dn_in;
         mark_ff  <= mark_in;
         level_ff <= level_in;
         run_ff   <= run_in;
      end
   end

   assign step_o.level = level_in;
   assign step_o.run   = run_in;
   assign step_o.pulse = pulse;

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff >= LVL_MIN_V && level_ff <= LVL_MAX_V)
      else $error("level out of range");

   a_shutdown_clears: assert property (@(posedge clock) disable iff (reset)
      fire && pulse |=> !run_ff && idle_ff == '0 && up_ff == '0 && dn_ff == '0)
      else $error("shutdown did not clear state");

   a_quiet_holds: assert property (@(posedge clock) disable iff (reset)
      fire && !active |=> up_ff == $past(up_ff) && dn_ff == $past(dn_ff)
                          && level_ff == $past(level_ff))
      else $error("buttons acted during quiet time");

endmodule

/* hw/rtl/two_button_level_controller.sv */
// channel | dir | tdata fields, lowest bit first             | tuser
// req     | in  | elapsed_us[20:0], up_level, down_level, pad | -
// rsp     | out | level[4:0], top_intensity[8:5],             | -
//         |     | run_enabled, shutdown_pulse, pad            |
// csr     | in  | write enable, 2-bit index, 23-bit data      | -
//
// one transaction per cycle sustained while rsp_tready holds; req reaches rsp
// through the input register, then next-state logic into the result register
// the timer/level state updates in the same cycle its transaction leaves
// the input register, so consecutive transactions chain without bubbles
// synchronous reset restores register defaults, level 1 and run enabled
// a stalled rsp holds both stages; req_tready drops only when both are full
module two_button_level_controller #(
   parameter int LEVEL_MAX = 20
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,  // elapsed_us, up_level, down_level
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,  // level, top_intensity, run, pulse
   input  logic                           csr_we,
   input  logic [tblc_pkg::CSR_IDX_W-1:0] csr_addr,
   input  logic [tblc_pkg::TIME_W-1:0]    csr_wdata
);
   import tblc_pkg::*;

   localparam int TBL_N = 2 ** LEVEL_W;

   csr_type      csr;
   step_in_type  in_ff;
   step_out_type step_res;
   logic         in_valid_ff, rsp_valid_ff, adv, fire;
   logic [LEVEL_W-1:0]  rsp_level_ff;
   logic [INTENS_W-1:0] rsp_intens_ff;
   logic                rsp_run_ff, rsp_pulse_ff;
   logic [INTENS_W-1:0] intens_tbl [TBL_N];

   for (genvar i = 0; i < TBL_N; i++) begin : g_intens
      localparam int TI = (13 * i + LEVEL_MAX - 1) / LEVEL_MAX - 1;
      assign intens_tbl[i] = INTENS_W'(TI);
   end

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && adv;
   assign req_tready = !in_valid_ff || adv;

   tblc_csr #(.LEVEL_MAX(LEVEL_MAX)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .csr_o     (csr)
   );

   tblc_step #(.LEVEL_MAX(LEVEL_MAX)) u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .csr_i  (csr),
      .step_i (in_ff),
      .step_o (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (adv) rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff.elapsed <= req_tdata[DT_W-1:0];
         in_ff.up      <= req_tdata[DT_W];
         in_ff.down    <= req_tdata[DT_W+1];
      end
      if (fire) begin
         rsp_level_ff  <= step_res.level;
         rsp_intens_ff <= intens_tbl[step_res.level];
         rsp_run_ff    <= step_res.run;
         rsp_pulse_ff  <= step_res.pulse;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_pulse_ff, rsp_run_ff, rsp_intens_ff, rsp_level_ff};

endmodule
